FILE: sv/bafp_pkg.sv
// bafp_pkg: shared types and constants for the bearing pipeline
// angle format, cordic arctangent table and the stage control struct
// no dependencies
`timescale 1ns / 1ps

package bafp_pkg;

    // angle accumulator: signed degrees with ANG_FRAC fractional bits
    localparam int ANG_FRAC  = 20;
    localparam int ANG_W     = 31;
    // folded angle in [0, 360) degrees fits in this many unsigned bits
    localparam int FOLD_W    = 29;
    // vector components are the coordinate differences scaled by 2^GUARD
    localparam int GUARD     = 24;
    localparam int TABLE_LEN = 24;
    localparam int ATAN_W    = 27;

    localparam logic signed [ANG_W-1:0] DEG90  = ANG_W'(90) <<< ANG_FRAC;
    localparam logic signed [ANG_W-1:0] DEG360 = ANG_W'(360) <<< ANG_FRAC;

    // atan(2^-i) in degrees times 2^20, rounded to nearest
    localparam logic [ATAN_W-1:0] ATAN_TAB [TABLE_LEN] = '{
        27'd47185920, 27'd27855475, 27'd14718068, 27'd7471121,
        27'd3750058,  27'd1876857,  27'd938658,   27'd469357,
        27'd234682,   27'd117342,   27'd58671,    27'd29335,
        27'd14668,    27'd7334,     27'd3667,     27'd1833,
        27'd917,      27'd458,      27'd229,      27'd115,
        27'd57,       27'd29,       27'd14,       27'd7
    };

    typedef struct packed {
        logic valid;
        logic same;   // center and target coincide
    } bafp_ctl_t;

endpackage

FILE: sv/bafp_prep.sv
// bafp_prep: first pipeline stage, coordinate differences and quadrant pre-rotation
// depends on bafp_pkg
`timescale 1ns / 1ps

module bafp_prep #(
    parameter int COORD_WIDTH = 16,
    parameter int VEC_W       = 43
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            valid_up,
    output logic                            ready_up,
    input  logic signed [COORD_WIDTH-1:0]   center_x,
    input  logic signed [COORD_WIDTH-1:0]   center_y,
    input  logic signed [COORD_WIDTH-1:0]   target_x,
    input  logic signed [COORD_WIDTH-1:0]   target_y,
    input  logic                            ready_dn,
    output bafp_pkg::bafp_ctl_t             ctl_dn,
    output logic signed [VEC_W-1:0]         x_dn,
    output logic signed [VEC_W-1:0]         y_dn,
    output logic signed [bafp_pkg::ANG_W-1:0] z_dn
);
    import bafp_pkg::*;

    localparam int DW = COORD_WIDTH + 1;

    logic signed [DW-1:0]    dx;
    logic signed [DW-1:0]    dy;
    logic signed [DW-1:0]    ndx;
    logic signed [DW-1:0]    ndy;
    logic signed [DW-1:0]    x_sel;
    logic signed [DW-1:0]    y_sel;
    logic signed [ANG_W-1:0] z_sel;

    logic                    valid_reg;
    logic                    same_reg;
    logic signed [VEC_W-1:0] x_reg;
    logic signed [VEC_W-1:0] y_reg;
    logic signed [ANG_W-1:0] z_reg;

    // negated differences formed directly so no negate follows the subtract
    assign dx  = {target_x[COORD_WIDTH-1], target_x} - {center_x[COORD_WIDTH-1], center_x};
    assign dy  = {target_y[COORD_WIDTH-1], target_y} - {center_y[COORD_WIDTH-1], center_y};
    assign ndx = {center_x[COORD_WIDTH-1], center_x} - {target_x[COORD_WIDTH-1], target_x};
    assign ndy = {center_y[COORD_WIDTH-1], center_y} - {target_y[COORD_WIDTH-1], target_y};

    always_comb
    begin
        priority if (dx[DW-1] && !dy[DW-1])
        begin
            x_sel = dy;
            y_sel = ndx;
            z_sel = DEG90;
        end
        else if (dx[DW-1])
        begin
            x_sel = ndy;
            y_sel = dx;
            z_sel = -DEG90;
        end
        else
        begin
            x_sel = dx;
            y_sel = dy;
            z_sel = '0;
        end
    end

    assign ready_up = !valid_reg || ready_dn;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_up)
        begin
            valid_reg <= valid_up;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_up && valid_up)
        begin
            same_reg <= (dx == '0) && (dy == '0);
            x_reg    <= {{(VEC_W-DW-GUARD){x_sel[DW-1]}}, x_sel, {GUARD{1'b0}}};
            y_reg    <= {{(VEC_W-DW-GUARD){y_sel[DW-1]}}, y_sel, {GUARD{1'b0}}};
            z_reg    <= z_sel;
        end
    end

    assign ctl_dn.valid = valid_reg;
    assign ctl_dn.same  = same_reg;
    assign x_dn         = x_reg;
    assign y_dn         = y_reg;
    assign z_dn         = z_reg;

endmodule

FILE: sv/bafp_cordic_stage.sv
// bafp_cordic_stage: one registered cordic vectoring iteration
// depends on bafp_pkg for the arctangent table and control struct
`timescale 1ns / 1ps

module bafp_cordic_stage #(
    parameter int STAGE = 0,
    parameter int VEC_W = 43
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bafp_pkg::bafp_ctl_t               ctl_up,
    input  logic signed [VEC_W-1:0]           x_up,
    input  logic signed [VEC_W-1:0]           y_up,
    input  logic signed [bafp_pkg::ANG_W-1:0] z_up,
    output logic                              ready_up,
    input  logic                              ready_dn,
    output bafp_pkg::bafp_ctl_t               ctl_dn,
    output logic signed [VEC_W-1:0]           x_dn,
    output logic signed [VEC_W-1:0]           y_dn,
    output logic signed [bafp_pkg::ANG_W-1:0] z_dn
);
    import bafp_pkg::*;

    localparam logic signed [ANG_W-1:0] STEP_ANG =
        {{(ANG_W-ATAN_W){1'b0}}, ATAN_TAB[STAGE]};

    logic signed [VEC_W-1:0] xs;
    logic signed [VEC_W-1:0] ys;
    logic signed [VEC_W-1:0] x_next;
    logic signed [VEC_W-1:0] y_next;
    logic signed [ANG_W-1:0] z_next;

    logic                    valid_reg;
    logic                    same_reg;
    logic signed [VEC_W-1:0] x_reg;
    logic signed [VEC_W-1:0] y_reg;
    logic signed [ANG_W-1:0] z_reg;

    assign xs = x_up >>> STAGE;
    assign ys = y_up >>> STAGE;

    // rotate toward the x axis, direction from the sign of y
    always_comb
    begin
        if (y_up[VEC_W-1])
        begin
            x_next = x_up - ys;
            y_next = y_up + xs;
            z_next = z_up - STEP_ANG;
        end
        else
        begin
            x_next = x_up + ys;
            y_next = y_up - xs;
            z_next = z_up + STEP_ANG;
        end
    end

    assign ready_up = !valid_reg || ready_dn;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_up)
        begin
            valid_reg <= ctl_up.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_up && ctl_up.valid)
        begin
            same_reg <= ctl_up.same;
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
        end
    end

    assign ctl_dn.valid = valid_reg;
    assign ctl_dn.same  = same_reg;
    assign x_dn         = x_reg;
    assign y_dn         = y_reg;
    assign z_dn         = z_reg;

endmodule

FILE: sv/bafp_finish.sv
// bafp_finish: two stages that add 90 degrees, fold into [0, 360) and round
// depends on bafp_pkg for the angle format
`timescale 1ns / 1ps

module bafp_finish #(
    parameter int FRAC_BITS = 6
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bafp_pkg::bafp_ctl_t               ctl_up,
    input  logic signed [bafp_pkg::ANG_W-1:0] z_up,
    output logic                              ready_up,
    input  logic                              ready_dn,
    output logic                              valid_dn,
    output logic [9+FRAC_BITS-1:0]            bearing
);
    import bafp_pkg::*;

    localparam int SHIFT = ANG_FRAC - FRAC_BITS;
    localparam int RW    = FOLD_W + 1 - SHIFT;
    localparam logic [FOLD_W:0]           ROUND_HALF = {{FOLD_W{1'b0}}, 1'b1} << (SHIFT - 1);
    localparam logic [RW-1:0]             WRAP       = RW'(360) << FRAC_BITS;
    localparam logic signed [ANG_W-1:0]   DEG450     = DEG90 + DEG360;
    localparam logic signed [ANG_W-1:0]   DEGM270    = DEG90 - DEG360;

    logic signed [ANG_W-1:0] v_mid;
    logic signed [ANG_W-1:0] v_lo;
    logic signed [ANG_W-1:0] v_hi;
    logic signed [ANG_W-1:0] v_fold;
    logic [FOLD_W:0]         v_sum;
    logic [RW-1:0]           r_full;
    logic [RW-1:0]           r_wrap;

    logic                    fold_valid_reg;
    logic [FOLD_W-1:0]       fold_reg;
    logic                    fold_ready;
    logic                    out_valid_reg;
    logic [9+FRAC_BITS-1:0]  bearing_reg;

    // all three fold candidates in parallel, pick by the unfolded sum
    assign v_mid = z_up + DEG90;
    assign v_lo  = z_up + DEG450;
    assign v_hi  = z_up + DEGM270;

    always_comb
    begin
        priority if (ctl_up.same)
        begin
            v_fold = DEG90;
        end
        else if (v_mid[ANG_W-1])
        begin
            v_fold = v_lo;
        end
        else if (v_mid >= DEG360)
        begin
            v_fold = v_hi;
        end
        else
        begin
            v_fold = v_mid;
        end
    end

    assign ready_up = !fold_valid_reg || fold_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_valid_reg <= 1'b0;
        end
        else if (ready_up)
        begin
            fold_valid_reg <= ctl_up.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_up && ctl_up.valid)
        begin
            fold_reg <= v_fold[FOLD_W-1:0];
        end
    end

    // round half up, then wrap a result of exactly 360 to 0
    assign v_sum  = {1'b0, fold_reg} + ROUND_HALF;
    assign r_full = v_sum[FOLD_W:SHIFT];
    assign r_wrap = (r_full >= WRAP) ? (r_full - WRAP) : r_full;

    assign fold_ready = !out_valid_reg || ready_dn;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fold_ready)
        begin
            out_valid_reg <= fold_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fold_ready && fold_valid_reg)
        begin
            bearing_reg <= r_wrap[9+FRAC_BITS-1:0];
        end
    end

    assign valid_dn = out_valid_reg;
    assign bearing  = bearing_reg;

endmodule

FILE: sv/bearing_angle_from_points.sv
// bearing_angle_from_points: pipelined cordic bearing from a center to a target point
// uses bafp_pkg, bafp_prep, bafp_cordic_stage and bafp_finish
//
//   channel   handshake              payload
//   request   req_valid/req_ready    center_x, center_y, target_x, target_y
//   result    rsp_valid/rsp_ready    bearing (degrees * 2^FRAC_BITS, 0 up, clockwise)
//
// one request per clock while the result side accepts; registers: one difference stage,
// one register per cordic iteration and two for fold and rounding
// every stage holds its own valid bit and takes new data when empty or when the next
// stage moves, so empty slots close up while the result side stalls
// reset clears only the valid bits
`timescale 1ns / 1ps

module bearing_angle_from_points #(
    parameter int COORD_WIDTH   = 16,
    parameter int CORDIC_STAGES = 16,
    parameter int FRAC_BITS     = 6
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic signed [COORD_WIDTH-1:0] center_x,
    input  logic signed [COORD_WIDTH-1:0] center_y,
    input  logic signed [COORD_WIDTH-1:0] target_x,
    input  logic signed [COORD_WIDTH-1:0] target_y,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output logic [9+FRAC_BITS-1:0]        bearing
);
    import bafp_pkg::*;

    // differences need COORD_WIDTH+1 bits, cordic gain and rotation need two more
    localparam int VEC_W = COORD_WIDTH + 3 + GUARD;

    bafp_ctl_t               ctl_s [CORDIC_STAGES+1];
    logic signed [VEC_W-1:0] x_s   [CORDIC_STAGES+1];
    logic signed [VEC_W-1:0] y_s   [CORDIC_STAGES+1];
    logic signed [ANG_W-1:0] z_s   [CORDIC_STAGES+1];
    logic                    rdy_s [CORDIC_STAGES+1];

    bafp_prep #(
        .COORD_WIDTH (COORD_WIDTH),
        .VEC_W       (VEC_W)
    ) u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid_up (req_valid),
        .ready_up (req_ready),
        .center_x (center_x),
        .center_y (center_y),
        .target_x (target_x),
        .target_y (target_y),
        .ready_dn (rdy_s[0]),
        .ctl_dn   (ctl_s[0]),
        .x_dn     (x_s[0]),
        .y_dn     (y_s[0]),
        .z_dn     (z_s[0])
    );

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        bafp_cordic_stage #(
            .STAGE (i),
            .VEC_W (VEC_W)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl_up   (ctl_s[i]),
            .x_up     (x_s[i]),
            .y_up     (y_s[i]),
            .z_up     (z_s[i]),
            .ready_up (rdy_s[i]),
            .ready_dn (rdy_s[i+1]),
            .ctl_dn   (ctl_s[i+1]),
            .x_dn     (x_s[i+1]),
            .y_dn     (y_s[i+1]),
            .z_dn     (z_s[i+1])
        );
    end

    bafp_finish #(
        .FRAC_BITS (FRAC_BITS)
    ) u_finish (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl_up   (ctl_s[CORDIC_STAGES]),
        .z_up     (z_s[CORDIC_STAGES]),
        .ready_up (rdy_s[CORDIC_STAGES]),
        .ready_dn (rsp_ready),
        .valid_dn (rsp_valid),
        .bearing  (bearing)
    );

endmodule

FILE: tb/sv/bearing_result_check.sv
// bearing_result_check: predicts and checks every result of bearing_angle_from_points
// watches both handshakes, computes the expected bearing per request by cordic vectoring
// no dependencies beyond the port widths of the block
`timescale 1ns / 1ps

module bearing_result_check #(
    parameter int COORD_WIDTH   = 16,
    parameter int CORDIC_STAGES = 16,
    parameter int FRAC_BITS     = 6
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic                          req_ready,
    input  logic signed [COORD_WIDTH-1:0] center_x,
    input  logic signed [COORD_WIDTH-1:0] center_y,
    input  logic signed [COORD_WIDTH-1:0] target_x,
    input  logic signed [COORD_WIDTH-1:0] target_y,
    input  logic                          rsp_valid,
    input  logic                          rsp_ready,
    input  logic [9+FRAC_BITS-1:0]        bearing,
    output int                            mismatch_count,
    output int                            in_flight
);

    localparam int ANG_FRAC    = 20;
    localparam int GUARD_SHIFT = 24;
    localparam int ATAN_LEN    = 24;
    localparam int STEPS       = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;
    localparam int BEARING_W   = 9 + FRAC_BITS;
    localparam longint QUARTER = longint'(90) <<< ANG_FRAC;
    localparam longint FULL    = longint'(360) <<< ANG_FRAC;
    localparam longint FULL_OUT = longint'(360) <<< FRAC_BITS;

    // atan(2^-i) in degrees, 20 fractional bits
    localparam int ATAN_DEG_Q20 [ATAN_LEN] = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
        234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29, 14, 7
    };

    typedef struct {
        logic signed [COORD_WIDTH-1:0] cx;
        logic signed [COORD_WIDTH-1:0] cy;
        logic signed [COORD_WIDTH-1:0] tx;
        logic signed [COORD_WIDTH-1:0] ty;
        logic [BEARING_W-1:0]          angle;
    } bearing_req_t;

    bearing_req_t expected_bearings [$];
    bearing_req_t oldest;
    bearing_req_t fresh;

    function automatic logic [BEARING_W-1:0] cordic_bearing(
        input logic signed [COORD_WIDTH-1:0] cx,
        input logic signed [COORD_WIDTH-1:0] cy,
        input logic signed [COORD_WIDTH-1:0] tx,
        input logic signed [COORD_WIDTH-1:0] ty
    );
        longint dx, dy, vx, vy, acc, xs, ys, folded, rounded;
        int i;
        dx = longint'(tx) - longint'(cx);
        dy = longint'(ty) - longint'(cy);
        if (dx == 0 && dy == 0)
            return BEARING_W'(longint'(90) <<< FRAC_BITS);
        // left half plane: turn by a quarter first so cordic converges
        if (dx < 0) begin
            if (dy >= 0) begin
                vx  = dy;
                vy  = -dx;
                acc = QUARTER;
            end
            else begin
                vx  = -dy;
                vy  = dx;
                acc = -QUARTER;
            end
        end
        else begin
            vx  = dx;
            vy  = dy;
            acc = 0;
        end
        vx = vx * (longint'(1) <<< GUARD_SHIFT);
        vy = vy * (longint'(1) <<< GUARD_SHIFT);
        for (i = 0; i < STEPS; i++) begin
            xs = vx >>> i;
            ys = vy >>> i;
            if (vy < 0) begin
                vx  = vx - ys;
                vy  = vy + xs;
                acc = acc - longint'(ATAN_DEG_Q20[i]);
            end
            else begin
                vx  = vx + ys;
                vy  = vy - xs;
                acc = acc + longint'(ATAN_DEG_Q20[i]);
            end
        end
        folded = acc + QUARTER;
        if (folded < 0)
            folded = folded + FULL;
        if (folded >= FULL)
            folded = folded - FULL;
        rounded = (folded + (longint'(1) <<< (ANG_FRAC - 1 - FRAC_BITS)))
                  >>> (ANG_FRAC - FRAC_BITS);
        // rounding up to a full turn wraps to zero
        if (rounded >= FULL_OUT)
            rounded = rounded - FULL_OUT;
        return BEARING_W'(rounded);
    endfunction

    initial
    begin
        mismatch_count = 0;
        in_flight      = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (req_valid && req_ready) begin
                fresh.cx    = center_x;
                fresh.cy    = center_y;
                fresh.tx    = target_x;
                fresh.ty    = target_y;
                fresh.angle = cordic_bearing(center_x, center_y, target_x, target_y);
                expected_bearings.push_back(fresh);
            end
            if (rsp_valid && rsp_ready) begin
                if (expected_bearings.size() == 0) begin
                    $display("%0t unexpected bearing %0d with no request pending",
                             $time, bearing);
                    mismatch_count <= mismatch_count + 1;
                end
                else begin
                    oldest = expected_bearings.pop_front();
                    if (bearing !== oldest.angle) begin
                        $display("%0t bearing mismatch (%0d,%0d)->(%0d,%0d): expected %0d, actual %0d",
                                 $time, oldest.cx, oldest.cy, oldest.tx, oldest.ty,
                                 oldest.angle, bearing);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            in_flight <= expected_bearings.size();
        end
    end

endmodule

FILE: tb/sv/tb_bearing_angle_from_points.sv
// tb_bearing_angle_from_points: stimulus, back-pressure and verdict for the bearing block
// depends on bearing_angle_from_points and bearing_result_check
// directed corner requests, then three random phases with varying idle rates
`timescale 1ns / 1ps

module tb_bearing_angle_from_points;

    localparam int COORD_WIDTH   = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int FRAC_BITS     = 6;
    localparam int PHASE_REQS    = 284;
    localparam int SETTLE_CYCLES = CORDIC_STAGES + 20;
    localparam int STALL_LIMIT   = 5000;
    localparam int DIRECTED_N    = 23;

    // packed as {center_x, center_y, target_x, target_y}
    localparam logic [63:0] DIRECTED_PAIRS [DIRECTED_N] = '{
        {16'h0000, 16'h0000, 16'h0000, 16'h0000},  // equal points at origin
        {16'h8000, 16'h8000, 16'h8000, 16'h8000},
        {16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff},
        {16'h8000, 16'h0000, 16'h7fff, 16'h0000},  // largest positive dx
        {16'h7fff, 16'h0000, 16'h8000, 16'h0000},  // largest negative dx
        {16'h0000, 16'h8000, 16'h0000, 16'h7fff},
        {16'h0000, 16'h7fff, 16'h0000, 16'h8000},
        {16'h0001, 16'h7fff, 16'h0000, 16'h8000},  // just left of up, rounds to a full turn
        {16'h0000, 16'h7fff, 16'h0001, 16'h8000},
        {16'h7fff, 16'h0000, 16'h8000, 16'h0001},  // near +-180 before the fold
        {16'h7fff, 16'h0000, 16'h8000, 16'hffff},
        {16'h0000, 16'h0000, 16'h0001, 16'h0000},
        {16'h0000, 16'h0000, 16'hffff, 16'h0000},
        {16'h0000, 16'h0000, 16'h0000, 16'h0001},
        {16'h0000, 16'h0000, 16'h0000, 16'hffff},
        {16'h0000, 16'h0000, 16'h0001, 16'h0001},
        {16'h0000, 16'h0000, 16'hffff, 16'hffff},
        {16'h0000, 16'h0000, 16'h0001, 16'hffff},
        {16'h0000, 16'h0000, 16'hffff, 16'h0001},
        {16'h7fff, 16'h7fff, 16'h8000, 16'h8000},
        {16'h8000, 16'h8000, 16'h7fff, 16'h7fff},
        {16'h5555, 16'haaaa, 16'haaaa, 16'h5555},
        {16'haaaa, 16'h5555, 16'h5555, 16'haaaa}
    };

    logic                          clk;
    logic                          rst_n;
    logic                          req_valid;
    logic                          req_ready;
    logic signed [COORD_WIDTH-1:0] center_x;
    logic signed [COORD_WIDTH-1:0] center_y;
    logic signed [COORD_WIDTH-1:0] target_x;
    logic signed [COORD_WIDTH-1:0] target_y;
    logic                          rsp_valid;
    logic                          rsp_ready;
    logic [9+FRAC_BITS-1:0]        bearing;

    int mismatch_count;
    int in_flight;
    int send_idle_pct;
    int recv_idle_pct;
    int stall_cycles;

    bearing_angle_from_points #(
        .COORD_WIDTH  (COORD_WIDTH),
        .CORDIC_STAGES(CORDIC_STAGES),
        .FRAC_BITS    (FRAC_BITS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .center_x (center_x),
        .center_y (center_y),
        .target_x (target_x),
        .target_y (target_y),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .bearing  (bearing)
    );

    bearing_result_check #(
        .COORD_WIDTH  (COORD_WIDTH),
        .CORDIC_STAGES(CORDIC_STAGES),
        .FRAC_BITS    (FRAC_BITS)
    ) i_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .center_x      (center_x),
        .center_y      (center_y),
        .target_x      (target_x),
        .target_y      (target_y),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .bearing       (bearing),
        .mismatch_count(mismatch_count),
        .in_flight     (in_flight)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ends the run when neither channel moves for too long
    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                stall_cycles = 0;
            else
                stall_cycles = stall_cycles + 1;
        end
        $display("bearing_angle_from_points regression: fail");
        $finish;
    end

    task automatic send_point_pair(input logic [63:0] pair);
        while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        center_x  <= pair[63:48];
        center_y  <= pair[47:32];
        target_x  <= pair[31:16];
        target_y  <= pair[15:0];
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    // hold off requests until every result is back
    task automatic drain_results();
        req_valid <= 1'b0;
        @(posedge clk);
        while (in_flight != 0)
            @(posedge clk);
    endtask

    function automatic logic [15:0] corner_coord();
        case ($urandom_range(4))
            0: return 16'h8000;
            1: return 16'hffff;
            2: return 16'h0000;
            3: return 16'h0001;
            default: return 16'h7fff;
        endcase
    endfunction

    function automatic logic [63:0] random_point_pair();
        logic [15:0] cx, cy, tx, ty;
        cx = 16'($urandom);
        cy = 16'($urandom);
        tx = 16'($urandom);
        ty = 16'($urandom);
        case ($urandom_range(9))
            0: begin
                tx = cx;
                ty = cy;
            end
            1: begin
                if ($urandom_range(1))
                    tx = cx;
                else
                    ty = cy;
            end
            2, 3: begin
                // target close to center, fine angles near every octant
                tx = cx + 16'($urandom_range(8)) - 16'd4;
                ty = cy + 16'($urandom_range(8)) - 16'd4;
            end
            4: begin
                cx = corner_coord();
                cy = corner_coord();
                tx = corner_coord();
                ty = corner_coord();
            end
            default: ;
        endcase
        return {cx, cy, tx, ty};
    endfunction

    initial
    begin
        int phase;
        int n;
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        rsp_ready     = 1'b0;
        center_x      = '0;
        center_y      = '0;
        target_x      = '0;
        target_y      = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 21;
        recv_idle_pct = 86;
        for (n = 0; n < DIRECTED_N; n++)
            send_point_pair(DIRECTED_PAIRS[n]);
        drain_results();

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 21;
                    recv_idle_pct = 86;
                end
                1: begin
                    send_idle_pct = 86;
                    recv_idle_pct = 21;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (n = 0; n < PHASE_REQS; n++)
                send_point_pair(random_point_pair());
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && in_flight == 0)
            $display("bearing_angle_from_points regression: pass");
        else
            $display("bearing_angle_from_points regression: fail");
        $finish;
    end

endmodule
